// ===== rtl/nrc_pkg.sv =====
// shared types and constants of the ntp response checker
package nrc_pkg;

   localparam int PACKET_BYTES = 48;
   localparam int COUNT_CAP    = PACKET_BYTES + 1;
   localparam int COUNT_W      = $clog2(COUNT_CAP + 1);

   localparam logic [31:0] ERA_OFFSET  = 32'd2208988800;
   localparam logic [7:0]  STRATUM_MIN = 8'd1;
   localparam logic [7:0]  STRATUM_MAX = 8'd15;

   // byte positions of the captured fields
   localparam logic [COUNT_W-1:0] STRATUM_POS = COUNT_W'(1);
   localparam logic [COUNT_W-1:0] REF_FIRST   = COUNT_W'(16);
   localparam logic [COUNT_W-1:0] REF_LAST    = COUNT_W'(19);
   localparam logic [COUNT_W-1:0] RCV_FIRST   = COUNT_W'(32);
   localparam logic [COUNT_W-1:0] RCV_LAST    = COUNT_W'(35);
   localparam logic [COUNT_W-1:0] XMT_FIRST   = COUNT_W'(40);
   localparam logic [COUNT_W-1:0] XMT_LAST    = COUNT_W'(43);

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_LENGTH   = 3'd1,
      ST_STRATUM  = 3'd2,
      ST_ZERO_REF = 3'd3,
      ST_ZERO_RCV = 3'd4,
      ST_ORDER    = 3'd5
   } status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] unix_seconds;
   } rsp_payload_type;

endpackage

// ===== rtl/nrc_req_if.sv =====
// byte channel into the checker
interface nrc_req_if;
   logic                     valid;
   logic                     ready;
   nrc_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/nrc_rsp_if.sv =====
// verdict channel out of the checker
interface nrc_rsp_if;
   logic                     valid;
   logic                     ready;
   nrc_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/ntp_response_checker_top.sv =====
// ntp server reply checker: byte counting, field capture and verdict
//
//   channel   dir  payload                          transfer when
//   req_chan  in   data_byte[7:0], last_byte        valid && ready
//   rsp_chan  out  status[2:0], unix_seconds[31:0]  valid && ready, one per last byte
//
// one byte a cycle while req_chan.ready is high; the verdict is registered, in the skid slot if the output stalls
// the output has a register and a skid slot, so bytes keep flowing while one verdict waits
// req_chan.ready drops only when both output slots are full
// synchronous reset clears the byte count and the output valids; captures are not reset
module ntp_response_checker_top (
   input  logic      clock,
   input  logic      reset,
   nrc_req_if.sink   req_chan,
   nrc_rsp_if.source rsp_chan
);

   logic [nrc_pkg::COUNT_W-1:0] count_ff, count_in, count_inc;
   logic [7:0]                  stratum_ff;
   logic [31:0]                 ref_ff, rcv_ff, xmt_ff;
   logic                        accept;
   logic                        push_ready;
   logic [7:0]                  byte_in;
   nrc_pkg::rsp_payload_type    verdict;

   assign accept  = req_chan.valid && req_chan.ready;
   assign byte_in = req_chan.payload.data_byte;

   // count saturates one past a full packet
   assign count_inc = (count_ff < nrc_pkg::COUNT_W'(nrc_pkg::COUNT_CAP)) ?
                      count_ff + nrc_pkg::COUNT_W'(1) : count_ff;

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         count_in = req_chan.payload.last_byte ? '0 : count_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // big-endian seconds words shift in a byte at a time
   always_ff @(posedge clock) begin
      if (accept) begin
         if (count_ff == nrc_pkg::STRATUM_POS) begin
            stratum_ff <= byte_in;
         end
         if (count_ff >= nrc_pkg::REF_FIRST && count_ff <= nrc_pkg::REF_LAST) begin
            ref_ff <= {ref_ff[23:0], byte_in};
         end
         if (count_ff >= nrc_pkg::RCV_FIRST && count_ff <= nrc_pkg::RCV_LAST) begin
            rcv_ff <= {rcv_ff[23:0], byte_in};
         end
         if (count_ff >= nrc_pkg::XMT_FIRST && count_ff <= nrc_pkg::XMT_LAST) begin
            xmt_ff <= {xmt_ff[23:0], byte_in};
         end
      end
   end

   // a full-length packet ends past all captured fields, so the registers are complete
   always_comb begin
      verdict.unix_seconds = '0;
      if (count_inc != nrc_pkg::COUNT_W'(nrc_pkg::PACKET_BYTES)) begin
         verdict.status = nrc_pkg::ST_LENGTH;
      end else if (stratum_ff < nrc_pkg::STRATUM_MIN || stratum_ff > nrc_pkg::STRATUM_MAX) begin
         verdict.status = nrc_pkg::ST_STRATUM;
      end else if (ref_ff == '0) begin
         verdict.status = nrc_pkg::ST_ZERO_REF;
      end else if (rcv_ff == '0) begin
         verdict.status = nrc_pkg::ST_ZERO_RCV;
      end else if (rcv_ff > xmt_ff) begin
         verdict.status = nrc_pkg::ST_ORDER;
      end else begin
         verdict.status       = nrc_pkg::ST_OK;
         verdict.unix_seconds = xmt_ff - nrc_pkg::ERA_OFFSET;
      end
   end

   assign req_chan.ready = push_ready;

   nrc_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_chan.valid && req_chan.payload.last_byte),
      .push_data  (verdict),
      .push_ready (push_ready),
      .rsp_chan   (rsp_chan)
   );

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= nrc_pkg::COUNT_W'(nrc_pkg::COUNT_CAP))
      else $error("byte count ran past its saturation point");

   a_count_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.payload.last_byte) |=> (count_ff == '0))
      else $error("byte count not cleared after the last byte");

   a_secs_only_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.payload.status != nrc_pkg::ST_OK)
      |-> (rsp_chan.payload.unix_seconds == '0))
      else $error("unix seconds given with a failing verdict");

   a_verdict_follows_last: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.payload.last_byte) |=> rsp_chan.valid)
      else $error("no verdict after the last byte");

endmodule

// ===== rtl/nrc_out_buf.sv =====
// two-entry output register with skid slot for the verdict channel
module nrc_out_buf (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid,
   input  nrc_pkg::rsp_payload_type push_data,
   output logic                     push_ready,
   nrc_rsp_if.source                rsp_chan
);

   logic                     out_valid_ff, out_valid_in;
   logic                     skid_valid_ff, skid_valid_in;
   nrc_pkg::rsp_payload_type out_data_ff, out_data_in;
   nrc_pkg::rsp_payload_type skid_data_ff, skid_data_in;
   logic                     push;

   assign push_ready = !skid_valid_ff;
   assign push       = push_valid && push_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (rsp_chan.ready || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_data_in  = push_data;
         end
      end else if (push) begin
         // output stalled: park the new verdict
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_data_ff;

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid slot holds a verdict while the output register is empty");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && rsp_chan.ready) |=> (out_valid_ff && !skid_valid_ff))
      else $error("parked verdict did not move to the output register");

   a_stall_holds_skid: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp_chan.ready) |=> (skid_valid_ff && $stable(skid_data_ff)))
      else $error("parked verdict lost during a stall");

endmodule
